/* rtl/quadratic_root_solver_core_macros.svh */
// assertion macros for the quadratic root solver
`ifndef QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH

// implication checked on every clock edge outside reset
`define QRS_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// fixed delay from trigger to consequence
`define QRS_ASSERT_DLY(lbl, pre, dly, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> ##dly (post)) \
    else $error(msg);

`endif

/* rtl/qrs_pkg.sv */
// ----------------------------------------------------------------------------
// qrs_pkg
// shared constants, solution codes and the words that travel along the cell rows
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

  localparam int FracBits   = 16;
  localparam int DeltaPairs = 17;
  localparam int SqrtSteps  = DeltaPairs + FracBits;
  localparam int RemW       = SqrtSteps + 2;
  localparam int DelW       = 2 * DeltaPairs;
  localparam int BaseW      = FracBits + 17;
  localparam int DenW       = 17;
  localparam int NumW       = FracBits + 18;
  localparam int RootW      = 34;
  localparam int PipeDepth  = 5 + SqrtSteps + NumW;

  localparam logic signed [NumW:0] RootMax =
    (NumW+1)'((64'sd1 <<< (RootW - 1)) - 64'sd1);
  localparam logic signed [NumW:0] RootMin = -RootMax - (NumW+1)'(1);

  typedef enum logic [2:0] {
    KIND_LIN_NONE = 3'd0,
    KIND_LIN_ALL  = 3'd1,
    KIND_LIN_ONE  = 3'd2,
    KIND_NO_REAL  = 3'd3,
    KIND_DOUBLE   = 3'd4,
    KIND_TWO      = 3'd5
  } kind_e;

  typedef struct packed {
    logic                    valid;
    kind_e                   kind;
    logic signed [BaseW-1:0] base;
    logic [DenW-1:0]         den_mag;
    logic                    den_neg;
    logic [DelW-1:0]         d;
    logic [RemW-1:0]         rem;
    logic [SqrtSteps-1:0]    root;
  } sqrt_word_t;

  typedef struct packed {
    logic            valid;
    kind_e           kind;
    logic [DenW-1:0] den_mag;
    logic            neg_lo;
    logic            neg_hi;
    logic [NumW-1:0] nq_lo;
    logic [NumW-1:0] nq_hi;
    logic [DenW-1:0] r_lo;
    logic [DenW-1:0] r_hi;
  } div_word_t;

endpackage

`default_nettype wire

/* rtl/quadratic_root_solver_core.sv */
// throughput: one equation per cycle, busy never rises
// the pipeline holds five stage registers, 33 square root cells and 34 divider cells
// reset clears every valid bit and cell word; no result strobes until fed again
// ----------------------------------------------------------------------------
// quadratic_root_solver_core
// solves ax^2+bx+c=0 through a multiplier front, a square root cell row
// and a divider cell row, giving the solution kind and fixed point roots
// ----------------------------------------------------------------------------
`default_nettype none

`include "quadratic_root_solver_core_macros.svh"

module quadratic_root_solver_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic signed [15:0]         coef_a_i,
  input  wire logic signed [15:0]         coef_b_i,
  input  wire logic signed [15:0]         coef_c_i,
  output logic                            valid_o,
  output logic [2:0]                      solution_kind_o,
  output logic signed [qrs_pkg::RootW-1:0] root_low_o,
  output logic signed [qrs_pkg::RootW-1:0] root_high_o
);

  assign busy = 1'b0;

  // input stage
  logic              in_vld_q;
  logic signed [15:0] a_q, b_q, c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= coef_a_i;
    b_q <= coef_b_i;
    c_q <= coef_c_i;
  end

  // product stage
  logic               p_vld_q;
  logic signed [31:0] bb_q, ac_q;
  logic signed [15:0] a1_q, b1_q, c1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bb_q <= b_q * b_q;
    ac_q <= a_q * c_q;
    a1_q <= a_q;
    b1_q <= b_q;
    c1_q <= c_q;
  end

  // discriminant and classification
  qrs_pkg::sqrt_word_t sq_w [qrs_pkg::SqrtSteps+1];
  qrs_pkg::sqrt_word_t s0_d, s0_q;
  logic signed [34:0] delta;
  logic signed [17:0] den_v;

  always_comb begin
    delta = 35'(bb_q) - (35'(ac_q) <<< 2);
    s0_d  = '0;
    s0_d.valid = p_vld_q;
    den_v = 18'(a1_q) <<< 1;
    s0_d.base  = -(qrs_pkg::BaseW'(b1_q) <<< qrs_pkg::FracBits);
    if (a1_q == 16'sd0) begin
      den_v = 18'(b1_q);
      if (b1_q == 16'sd0) begin
        s0_d.kind = (c1_q == 16'sd0) ? qrs_pkg::KIND_LIN_ALL : qrs_pkg::KIND_LIN_NONE;
        den_v     = 18'sd1;
      end else begin
        s0_d.kind = qrs_pkg::KIND_LIN_ONE;
        s0_d.base = -(qrs_pkg::BaseW'(c1_q) <<< qrs_pkg::FracBits);
      end
    end else if (delta < 35'sd0) begin
      s0_d.kind = qrs_pkg::KIND_NO_REAL;
    end else if (delta == 35'sd0) begin
      s0_d.kind = qrs_pkg::KIND_DOUBLE;
    end else begin
      s0_d.kind = qrs_pkg::KIND_TWO;
      s0_d.d    = delta[qrs_pkg::DelW-1:0];
    end
    s0_d.den_neg = den_v[17];
    s0_d.den_mag = qrs_pkg::DenW'(den_v[17] ? -den_v : den_v);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0;
    end else begin
      s0_q <= s0_d;
    end
  end

  assign sq_w[0] = s0_q;

  for (genvar i = 0; i < qrs_pkg::SqrtSteps; i++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .word_i (sq_w[i]),
      .word_o (sq_w[i+1])
    );
  end

  // numerators and signs for the divider row
  qrs_pkg::sqrt_word_t sw;
  qrs_pkg::div_word_t  dv_w [qrs_pkg::NumW+1];
  qrs_pkg::div_word_t  d0_d, d0_q;
  logic signed [qrs_pkg::NumW:0] base_x, s_x, num_lo, num_hi;

  always_comb begin
    sw     = sq_w[qrs_pkg::SqrtSteps];
    base_x = (qrs_pkg::NumW+1)'(sw.base);
    s_x    = $signed((qrs_pkg::NumW+1)'(sw.root));
    if (sw.kind == qrs_pkg::KIND_TWO) begin
      num_lo = base_x - s_x;
      num_hi = base_x + s_x;
    end else begin
      num_lo = base_x;
      num_hi = base_x;
    end
    d0_d         = '0;
    d0_d.valid   = sw.valid;
    d0_d.kind    = sw.kind;
    d0_d.den_mag = sw.den_mag;
    d0_d.neg_lo  = num_lo[qrs_pkg::NumW] ^ sw.den_neg;
    d0_d.neg_hi  = num_hi[qrs_pkg::NumW] ^ sw.den_neg;
    d0_d.nq_lo   = qrs_pkg::NumW'(num_lo[qrs_pkg::NumW] ? -num_lo : num_lo);
    d0_d.nq_hi   = qrs_pkg::NumW'(num_hi[qrs_pkg::NumW] ? -num_hi : num_hi);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d0_q <= '0;
    end else begin
      d0_q <= d0_d;
    end
  end

  assign dv_w[0] = d0_q;

  for (genvar j = 0; j < qrs_pkg::NumW; j++) begin : g_div
    qrs_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .word_i (dv_w[j]),
      .word_o (dv_w[j+1])
    );
  end

  // sign, saturation and zeroing of unused roots
  qrs_pkg::div_word_t dw;
  logic signed [qrs_pkg::NumW:0]    q_lo, q_hi, c_lo, c_hi;
  logic                             vld_q;
  logic [2:0]                       kind_q;
  logic signed [qrs_pkg::RootW-1:0] lo_d, hi_d, lo_q, hi_q;

  always_comb begin
    dw   = dv_w[qrs_pkg::NumW];
    q_lo = $signed({1'b0, dw.nq_lo});
    q_hi = $signed({1'b0, dw.nq_hi});
    if (dw.neg_lo) begin
      q_lo = -q_lo;
    end
    if (dw.neg_hi) begin
      q_hi = -q_hi;
    end
    c_lo = (q_lo > qrs_pkg::RootMax) ? qrs_pkg::RootMax :
           (q_lo < qrs_pkg::RootMin) ? qrs_pkg::RootMin : q_lo;
    c_hi = (q_hi > qrs_pkg::RootMax) ? qrs_pkg::RootMax :
           (q_hi < qrs_pkg::RootMin) ? qrs_pkg::RootMin : q_hi;
    lo_d = '0;
    hi_d = '0;
    case (dw.kind)
      qrs_pkg::KIND_LIN_ONE, qrs_pkg::KIND_DOUBLE: begin
        lo_d = c_lo[qrs_pkg::RootW-1:0];
      end
      qrs_pkg::KIND_TWO: begin
        lo_d = c_lo[qrs_pkg::RootW-1:0];
        hi_d = c_hi[qrs_pkg::RootW-1:0];
      end
      default: begin
        lo_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= dw.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= dw.kind;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
  end

  assign valid_o         = vld_q;
  assign solution_kind_o = kind_q;
  assign root_low_o      = lo_q;
  assign root_high_o     = hi_q;

  `QRS_ASSERT_DLY(a_fixed_latency, start && !busy, (qrs_pkg::PipeDepth), valid_o, "word lost in pipeline")
  `QRS_ASSERT_IMP(a_high_unused, valid_o && (solution_kind_o != qrs_pkg::KIND_TWO), root_high_o == '0, "second root not cleared")
  `QRS_ASSERT_IMP(a_low_unused, valid_o && (solution_kind_o == qrs_pkg::KIND_LIN_NONE || solution_kind_o == qrs_pkg::KIND_LIN_ALL || solution_kind_o == qrs_pkg::KIND_NO_REAL), root_low_o == '0, "first root not cleared")

endmodule

`default_nettype wire

/* rtl/qrs_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// one digit of the square root: brings down a bit pair and tries the next bit
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire qrs_pkg::sqrt_word_t word_i,
  output qrs_pkg::sqrt_word_t     word_o
);

  qrs_pkg::sqrt_word_t word_d, word_q;
  logic [qrs_pkg::RemW-1:0] rem_sh, trial;
  logic                     ge;

  always_comb begin
    rem_sh = {word_i.rem[qrs_pkg::RemW-3:0], word_i.d[qrs_pkg::DelW-1 -: 2]};
    trial  = {word_i.root, 2'b01};
    ge     = (rem_sh >= trial);
    word_d = word_i;
    word_d.d    = word_i.d << 2;
    word_d.rem  = ge ? (rem_sh - trial) : rem_sh;
    word_d.root = {word_i.root[qrs_pkg::SqrtSteps-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

/* rtl/qrs_div_cell.sv */
// ----------------------------------------------------------------------------
// qrs_div_cell
// one quotient bit of two restoring divisions sharing a divisor
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire qrs_pkg::div_word_t word_i,
  output qrs_pkg::div_word_t     word_o
);

  qrs_pkg::div_word_t word_d, word_q;
  logic [qrs_pkg::DenW:0] r_sh_lo, r_sh_hi, den_x;
  logic                   ge_lo, ge_hi;

  always_comb begin
    den_x   = {1'b0, word_i.den_mag};
    // numerator bits leave at the top while quotient bits enter at the bottom
    r_sh_lo = {word_i.r_lo, word_i.nq_lo[qrs_pkg::NumW-1]};
    r_sh_hi = {word_i.r_hi, word_i.nq_hi[qrs_pkg::NumW-1]};
    ge_lo   = (r_sh_lo >= den_x);
    ge_hi   = (r_sh_hi >= den_x);
    word_d  = word_i;
    word_d.r_lo  = qrs_pkg::DenW'(ge_lo ? (r_sh_lo - den_x) : r_sh_lo);
    word_d.r_hi  = qrs_pkg::DenW'(ge_hi ? (r_sh_hi - den_x) : r_sh_hi);
    word_d.nq_lo = {word_i.nq_lo[qrs_pkg::NumW-2:0], ge_lo};
    word_d.nq_hi = {word_i.nq_hi[qrs_pkg::NumW-2:0], ge_hi};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

`default_nettype wire
